FILE: rtl/dadt_pkg.sv
// Package for the detection argmax / dedup table block.
// Field widths, opcodes and the 30 percent box tolerance ratio.
// No dependencies.
package dadt_pkg;

   localparam int FIELD_W    = 16;   // coordinate port width
   localparam int SCORE_W    = 16;
   localparam int CLASS_W    = 8;
   localparam int NUM_COORDS = 4;

   // box tolerance: 10*|new-kept| <= 3*kept
   localparam int TOL_NUM = 3;
   localparam int TOL_DEN = 10;

   localparam logic [SCORE_W-1:0] THRESH_RESET = 16'd16384;

   localparam logic OP_SCORE = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

endpackage

FILE: rtl/detection_argmax_dedup_table.sv
// Per-anchor argmax with a de-duplicating table of kept detections. Score
// transactions (req_op = 0) are taken one per cycle while req_ready is high; the
// transaction that carries anchor_last moves to a close state for the anchor, then
// each kept entry is visited in turn through the single match unit until a match or
// the table end (the memory read port feeds one entry per cycle). A drain
// transaction (req_op = 1) emits the table in order, holding each result until
// rsp_ready, then clears it; an empty table gives one result with rsp_valid_res
// low. req_ready is low while an anchor close or a drain runs.
// The threshold register can be written at any time (csr_ready is always high).
// Depends on dadt_pkg, dadt_kept_mem and dadt_match_unit.
module detection_argmax_dedup_table import dadt_pkg::*; #(
   parameter int MAX_KEPT   = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SCORE_W-1:0]  csr_score_threshold,
   // input transactions
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [FIELD_W-1:0]  req_center_x,
   input  logic [FIELD_W-1:0]  req_center_y,
   input  logic [FIELD_W-1:0]  req_box_width,
   input  logic [FIELD_W-1:0]  req_box_height,
   input  logic [SCORE_W-1:0]  req_class_score,
   input  logic [CLASS_W-1:0]  req_class_index,
   input  logic                req_anchor_last,
   // results
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_valid_res,
   output logic [CLASS_W-1:0]  rsp_det_class,
   output logic [SCORE_W-1:0]  rsp_det_score,
   output logic [FIELD_W-1:0]  rsp_det_center_x,
   output logic [FIELD_W-1:0]  rsp_det_center_y,
   output logic [FIELD_W-1:0]  rsp_det_width,
   output logic [FIELD_W-1:0]  rsp_det_height,
   output logic                rsp_overflow,
   output logic                rsp_last
);

   localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W   = $clog2(MAX_KEPT + 1);
   localparam int NXT_W   = IDX_W + 1;
   localparam int BOX_W   = NUM_COORDS * COORD_BITS;
   localparam int ENTRY_W = CLASS_W + SCORE_W + BOX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLOSE = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DCAP  = 3'd3;
   localparam logic [2:0] ST_DWAIT = 3'd4;

   logic [2:0]          state_ff,      state_in;
   logic [IDX_W-1:0]    idx_ff,        idx_in;
   logic [CNT_W-1:0]    count_ff,      count_in;
   logic                ovf_ff,        ovf_in;
   logic [SCORE_W-1:0]  thr_ff,        thr_in;
   logic [SCORE_W-1:0]  best_score_ff, best_score_in;
   logic [CLASS_W-1:0]  best_class_ff, best_class_in;
   logic [BOX_W-1:0]    best_box_ff,   best_box_in;

   logic                out_vres_ff,   out_vres_in;
   logic [CLASS_W-1:0]  out_class_ff,  out_class_in;
   logic [SCORE_W-1:0]  out_score_ff,  out_score_in;
   logic [BOX_W-1:0]    out_box_ff,    out_box_in;
   logic                out_ovf_ff,    out_ovf_in;
   logic                out_last_ff,   out_last_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  rd_data;

   logic [CLASS_W-1:0]  kept_class;
   logic [SCORE_W-1:0]  kept_score;
   logic [BOX_W-1:0]    kept_box;
   logic                match;
   logic                higher;

   logic [NXT_W-1:0]    idx_nxt;
   logic                at_end;
   logic                has_room;
   logic [BOX_W-1:0]    req_box;

   assign kept_class = rd_data[ENTRY_W-1 -: CLASS_W];
   assign kept_score = rd_data[BOX_W +: SCORE_W];
   assign kept_box   = rd_data[BOX_W-1:0];

   assign idx_nxt  = NXT_W'(idx_ff) + NXT_W'(1);
   assign at_end   = (idx_nxt == NXT_W'(count_ff));
   assign has_room = (count_ff < CNT_W'(MAX_KEPT));
   assign req_box  = {req_box_height[COORD_BITS-1:0], req_box_width[COORD_BITS-1:0],
                      req_center_y[COORD_BITS-1:0], req_center_x[COORD_BITS-1:0]};

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DWAIT);

   dadt_kept_mem #(
      .MAX_KEPT (MAX_KEPT),
      .ENTRY_W  (ENTRY_W),
      .IDX_W    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dadt_match_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_match (
      .new_box    (best_box_ff),
      .kept_box   (kept_box),
      .new_class  (best_class_ff),
      .kept_class (kept_class),
      .new_score  (best_score_ff),
      .kept_score (kept_score),
      .match      (match),
      .higher     (higher)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      thr_in        = thr_ff;
      best_score_in = best_score_ff;
      best_class_in = best_class_ff;
      best_box_in   = best_box_ff;
      out_vres_in   = out_vres_ff;
      out_class_in  = out_class_ff;
      out_score_in  = out_score_ff;
      out_box_in    = out_box_ff;
      out_ovf_in    = out_ovf_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {best_class_ff, best_score_ff, best_box_ff};
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      if (csr_valid) begin
         thr_in = csr_score_threshold;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_SCORE) begin
                  if (req_class_score > thr_ff && req_class_score > best_score_ff) begin
                     best_score_in = req_class_score;
                     best_class_in = req_class_index;
                     best_box_in   = req_box;
                  end
                  if (req_anchor_last) begin
                     state_in = ST_CLOSE;
                  end
               end else if (count_ff == '0) begin
                  out_vres_in  = 1'b0;
                  out_class_in = '0;
                  out_score_in = '0;
                  out_box_in   = '0;
                  out_ovf_in   = ovf_ff;
                  out_last_in  = 1'b1;
                  state_in     = ST_DWAIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = ST_DCAP;
               end
            end
         end
         ST_CLOSE: begin
            if (best_score_ff == '0) begin
               state_in = ST_IDLE;
            end else if (count_ff == '0) begin
               // empty table: append straight away
               wr_en    = 1'b1;
               wr_addr  = '0;
               count_in = CNT_W'(1);
               state_in = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
            if (state_in == ST_IDLE) begin
               best_score_in = '0;
               best_class_in = '0;
               best_box_in   = '0;
            end
         end
         ST_SCAN: begin
            // rd_data holds entry idx_ff; entry idx_ff+1 is fetched if the walk goes on
            if (match) begin
               if (higher) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff;
               end
               state_in = ST_IDLE;
            end else if (at_end) begin
               if (has_room) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_nxt[IDX_W-1:0];
               idx_in  = idx_nxt[IDX_W-1:0];
            end
            if (state_in == ST_IDLE) begin
               best_score_in = '0;
               best_class_in = '0;
               best_box_in   = '0;
            end
         end
         ST_DCAP: begin
            out_vres_in  = 1'b1;
            out_class_in = kept_class;
            out_score_in = kept_score;
            out_box_in   = kept_box;
            out_ovf_in   = ovf_ff;
            out_last_in  = at_end;
            state_in     = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (rsp_ready) begin
               if (out_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_nxt[IDX_W-1:0];
                  idx_in   = idx_nxt[IDX_W-1:0];
                  state_in = ST_DCAP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         thr_ff        <= THRESH_RESET;
         best_score_ff <= '0;
         best_class_ff <= '0;
         best_box_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         thr_ff        <= thr_in;
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         best_box_ff   <= best_box_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      out_vres_ff  <= out_vres_in;
      out_class_ff <= out_class_in;
      out_score_ff <= out_score_in;
      out_box_ff   <= out_box_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid_res    = out_vres_ff;
   assign rsp_det_class    = out_class_ff;
   assign rsp_det_score    = out_score_ff;
   assign rsp_det_center_x = FIELD_W'(out_box_ff[0*COORD_BITS +: COORD_BITS]);
   assign rsp_det_center_y = FIELD_W'(out_box_ff[1*COORD_BITS +: COORD_BITS]);
   assign rsp_det_width    = FIELD_W'(out_box_ff[2*COORD_BITS +: COORD_BITS]);
   assign rsp_det_height   = FIELD_W'(out_box_ff[3*COORD_BITS +: COORD_BITS]);
   assign rsp_overflow     = out_ovf_ff;
   assign rsp_last         = out_last_ff;

endmodule

FILE: rtl/dadt_kept_mem.sv
// Kept-detection table storage: one write port, one registered read port.
// Entry layout is {class, score, box}. No package dependencies.
module dadt_kept_mem #(
   parameter int MAX_KEPT = 64,
   parameter int ENTRY_W  = 88,
   parameter int IDX_W    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem_ff [MAX_KEPT];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dadt_match_unit.sv
// Match unit shared by every step of the table walk: same class and all four
// coordinates within tolerance, plus the score compare. Uses dadt_pkg.
module dadt_match_unit import dadt_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic [NUM_COORDS*COORD_BITS-1:0] new_box,
   input  logic [NUM_COORDS*COORD_BITS-1:0] kept_box,
   input  logic [CLASS_W-1:0]               new_class,
   input  logic [CLASS_W-1:0]               kept_class,
   input  logic [SCORE_W-1:0]               new_score,
   input  logic [SCORE_W-1:0]               kept_score,
   output logic                             match,
   output logic                             higher
);

   localparam int LW = COORD_BITS + 4;   // holds 10 * coordinate

   logic [NUM_COORDS-1:0] close;

   for (genvar k = 0; k < NUM_COORDS; k++) begin : g_coord
      logic [COORD_BITS-1:0] n_c;
      logic [COORD_BITS-1:0] o_c;
      logic [COORD_BITS-1:0] diff;
      logic [LW-1:0]         lhs;
      logic [LW-1:0]         rhs;

      assign n_c  = new_box[k*COORD_BITS +: COORD_BITS];
      assign o_c  = kept_box[k*COORD_BITS +: COORD_BITS];
      assign diff = (n_c > o_c) ? (n_c - o_c) : (o_c - n_c);
      assign lhs  = LW'(TOL_DEN) * LW'(diff);
      assign rhs  = LW'(TOL_NUM) * LW'(o_c);
      assign close[k] = (lhs <= rhs);
   end

   assign match  = (new_class == kept_class) && (&close);
   assign higher = (new_score > kept_score);

endmodule
